### hdl/iba_pkg.sv
// Package for the inode bitmap allocator: beat types, opcodes, register indexes
// and engine state codes. No dependencies.
`default_nettype none
package iba_pkg;

    localparam int unsigned WORD_W = 64;

    typedef enum logic [1:0] {
        OP_LOAD_WORD  = 2'd0,
        OP_LOAD_GROUP = 2'd1,
        OP_LOAD_TOTAL = 2'd2,
        OP_ALLOCATE   = 2'd3
    } t_opcode;

    localparam logic REG_INODES_PER_GROUP = 1'b0;
    localparam logic REG_GROUP_COUNT      = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  group_sel;
        logic [6:0]  word_sel;
        logic [63:0] load_value;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic [17:0] inode_number;
        logic [3:0]  group_found;
        logic [13:0] group_free_left;
        logic [17:0] total_free_left;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROUP,
        ST_READ,
        ST_TEST,
        ST_MARK,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### hdl/iba_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module iba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hdl/iba_queue.sv
// Two-entry queue between the front end and the allocation engine.
// Depends on iba_pkg.
`default_nettype none
module iba_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  iba_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  wire               i_take,
    output iba_pkg::t_in_beat o_data
);

    iba_pkg::t_in_beat r_slot [2];
    logic              r_rd_ptr, r_wr_ptr;
    logic [1:0]        r_count;
    logic              push, pop;

    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = i_take && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

### hdl/iba_engine.sv
// Allocation engine: executes loads and the first-free search over the bitmap RAM.
// Depends on iba_pkg and iba_ram.
`default_nettype none
module iba_engine #(
    parameter int unsigned MAX_GROUPS      = 16,
    parameter int unsigned WORDS_PER_GROUP = 128
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  iba_pkg::t_in_beat  i_data,
    output logic               o_take,
    input  wire  [13:0]        i_inodes_per_group,
    input  wire  [4:0]         i_group_count,
    output logic               o_valid,
    input  wire                i_stall,
    output iba_pkg::t_out_beat o_data
);

    localparam int unsigned GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int unsigned WW    = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
    localparam int unsigned DEPTH = MAX_GROUPS * WORDS_PER_GROUP;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LIMW  = $clog2(WORDS_PER_GROUP * 64 + 1);
    localparam logic [LIMW-1:0] MAX_LIMIT = LIMW'(WORDS_PER_GROUP * 64);

    iba_pkg::t_state    r_state, n_state;
    logic [13:0]        r_gcnt [MAX_GROUPS];
    logic [17:0]        r_total;
    logic [8:0]         r_g;
    logic [WW:0]        r_w;
    logic [5:0]         r_bit;
    logic [63:0]        r_word;
    logic [LIMW-1:0]    r_limit;
    logic [8:0]         r_ngroups;
    logic [31:0]        r_prod;
    logic               r_out_valid;
    iba_pkg::t_out_beat r_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;
    logic               out_free;
    logic               out_load;
    logic [17:0]        load_total;
    logic [GW-1:0]      g_idx;
    logic [LIMW-1:0]    base, valid_n;
    logic [63:0]        freebits, mask;
    logic               found;
    logic [5:0]         low_idx;
    logic               load_ok;

    assign out_free   = !r_out_valid || !i_stall;
    assign out_load   = load_ok || (r_state == iba_pkg::ST_DONE && out_free);
    assign load_total = (i_data.opcode == iba_pkg::OP_LOAD_TOTAL)
                        ? i_data.load_value[17:0] : r_total;
    assign g_idx      = r_g[GW-1:0];
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    iba_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Free bits of the word read out in the test step, limited to the valid
    // range of the group.
    always_comb begin
        base    = LIMW'({r_w[WW-1:0], 6'd0});
        valid_n = r_limit - base;
        mask    = (valid_n >= LIMW'(64)) ? '1 : ((64'd1 << valid_n[5:0]) - 64'd1);
        freebits = ~ram_rdata & mask;
        found    = (freebits != 64'd0);
        low_idx  = 6'd0;
        for (int k = 63; k >= 0; k--) begin
            if (freebits[k]) low_idx = 6'(k);
        end
    end

    // Sequencer for loads and the search.
    always_comb begin
        n_state   = r_state;
        o_take    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'({g_idx, r_w[WW-1:0]});
        ram_wdata = r_word | (64'd1 << r_bit);
        ram_raddr = AW'({g_idx, r_w[WW-1:0]});
        load_ok   = 1'b0;
        unique case (r_state)
            iba_pkg::ST_IDLE: begin
                if (i_valid && out_free) begin
                    o_take = 1'b1;
                    if (i_data.opcode == iba_pkg::OP_ALLOCATE) begin
                        n_state = iba_pkg::ST_GROUP;
                    end else begin
                        load_ok = 1'b1;
                    end
                end
                ram_we    = load_ok && i_data.opcode == iba_pkg::OP_LOAD_WORD
                            && 32'(i_data.group_sel) < MAX_GROUPS
                            && 32'(i_data.word_sel) < WORDS_PER_GROUP;
                ram_waddr = AW'((32'(i_data.group_sel) * WORDS_PER_GROUP)
                                + 32'(i_data.word_sel));
                ram_wdata = i_data.load_value;
            end
            iba_pkg::ST_GROUP: begin
                if (r_g >= r_ngroups || r_limit == '0) begin
                    n_state = iba_pkg::ST_DONE;
                end else if (r_gcnt[g_idx] != 14'd0) begin
                    n_state = iba_pkg::ST_READ;
                end
            end
            iba_pkg::ST_READ: begin
                n_state = iba_pkg::ST_TEST;
            end
            iba_pkg::ST_TEST: begin
                if (found) begin
                    n_state = iba_pkg::ST_MARK;
                end else if (LIMW'(base + LIMW'(64)) >= r_limit
                             || 32'(r_w) + 1 >= WORDS_PER_GROUP) begin
                    n_state = iba_pkg::ST_GROUP;
                end else begin
                    n_state = iba_pkg::ST_READ;
                end
            end
            iba_pkg::ST_MARK: begin
                ram_we  = 1'b1;
                n_state = iba_pkg::ST_MUL;
            end
            iba_pkg::ST_MUL: begin
                n_state = iba_pkg::ST_DONE;
            end
            iba_pkg::ST_DONE: begin
                if (out_free) n_state = iba_pkg::ST_IDLE;
            end
            default: n_state = iba_pkg::ST_IDLE;
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iba_pkg::ST_IDLE;
            r_total     <= 18'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_GROUPS; i++) r_gcnt[i] <= 14'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && i_stall);
            unique case (r_state)
                iba_pkg::ST_IDLE: begin
                    if (load_ok) begin
                        r_out <= '{status: 1'b0, inode_number: 18'd0, group_found: 4'd0,
                                   group_free_left: 14'd0, total_free_left: load_total};
                        if (i_data.opcode == iba_pkg::OP_LOAD_GROUP
                            && 32'(i_data.group_sel) < MAX_GROUPS) begin
                            r_gcnt[i_data.group_sel[GW-1:0]] <= i_data.load_value[13:0];
                        end
                        if (i_data.opcode == iba_pkg::OP_LOAD_TOTAL) begin
                            r_total <= i_data.load_value[17:0];
                        end
                    end else if (o_take) begin
                        r_g       <= '0;
                        r_w       <= '0;
                        r_ngroups <= (i_group_count > 5'(MAX_GROUPS > 16 ? 16 : MAX_GROUPS))
                                     ? 9'(MAX_GROUPS > 16 ? 16 : MAX_GROUPS)
                                     : 9'(i_group_count);
                        r_limit   <= (32'(i_inodes_per_group) > 32'(MAX_LIMIT))
                                     ? MAX_LIMIT : LIMW'(i_inodes_per_group);
                        r_out     <= '{status: 1'b1, inode_number: 18'd0, group_found: 4'd0,
                                       group_free_left: 14'd0, total_free_left: 18'd0};
                    end
                end
                iba_pkg::ST_GROUP: begin
                    r_w <= '0;
                    if (r_g < r_ngroups && r_gcnt[g_idx] == 14'd0) r_g <= r_g + 9'd1;
                end
                iba_pkg::ST_TEST: begin
                    r_bit <= low_idx;
                    if (!found) begin
                        r_w <= r_w + 1'b1;
                        if (n_state == iba_pkg::ST_GROUP) r_g <= r_g + 9'd1;
                    end
                end
                iba_pkg::ST_MARK: begin
                    r_gcnt[g_idx] <= r_gcnt[g_idx] - 14'd1;
                    if (r_total != 18'd0) r_total <= r_total - 18'd1;
                    r_prod <= 32'(r_g) * 32'(i_inodes_per_group);
                end
                iba_pkg::ST_MUL: begin
                    r_out.status          <= 1'b0;
                    r_out.inode_number    <= 18'(r_prod + 32'({r_w[WW-1:0], r_bit}) + 32'd1);
                    r_out.group_found     <= 4'(r_g);
                    r_out.group_free_left <= r_gcnt[g_idx];
                end
                iba_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out.total_free_left <= r_total;
                    end
                end
                default: ;
            endcase
        end
    end

    // Word read out in the test step is held for the mark step.
    always_ff @(posedge i_clk) begin
        if (r_state == iba_pkg::ST_TEST) r_word <= ram_rdata;
    end

endmodule
`default_nettype wire

### hdl/inode_bitmap_allocator.sv
// Top level of the inode bitmap allocator: configuration registers, input queue
// and allocation engine. Depends on iba_pkg, iba_queue, iba_engine.
//
//  Channel  Direction  Handshake               Beat type
//  in       input      i_in_valid / o_in_stall iba_pkg::t_in_beat
//  out      output     o_out_valid / i_out_stall iba_pkg::t_out_beat
//  cfg      input      i_cfg_we                index + 14-bit data
//
// Every beat is registered in the queue before the engine takes it. A load
// result is valid the cycle after the engine takes the load. An allocation checks
// each group examined and reads and tests each bitmap word; when it finds an inode
// it marks the bit and forms the number before done, and else goes straight to done.
// Synchronous active-low reset clears the counts and restores the registers.
// A two-beat queue lets the input keep accepting while the engine waits on stall.
`default_nettype none
module inode_bitmap_allocator #(
    parameter int unsigned MAX_GROUPS      = 16,
    parameter int unsigned WORDS_PER_GROUP = 128
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  iba_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output iba_pkg::t_out_beat o_out_data,
    input  wire                i_cfg_we,
    input  wire  [0:0]         i_cfg_index,
    input  wire  [13:0]        i_cfg_data
);

    logic [13:0]       r_inodes_per_group;
    logic [4:0]        r_group_count;
    logic              q_valid, q_take;
    iba_pkg::t_in_beat q_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inodes_per_group <= 14'd8192;
            r_group_count      <= 5'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_index == iba_pkg::REG_INODES_PER_GROUP) r_inodes_per_group <= i_cfg_data;
            if (i_cfg_index == iba_pkg::REG_GROUP_COUNT)      r_group_count <= i_cfg_data[4:0];
        end
    end

    iba_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_stall(o_in_stall),
        .i_data (i_in_data),
        .o_valid(q_valid),
        .i_take (q_take),
        .o_data (q_data)
    );

    iba_engine #(
        .MAX_GROUPS     (MAX_GROUPS),
        .WORDS_PER_GROUP(WORDS_PER_GROUP)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_data            (q_data),
        .o_take            (q_take),
        .i_inodes_per_group(r_inodes_per_group),
        .i_group_count     (r_group_count),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_data            (o_out_data)
    );

endmodule
`default_nettype wire
